@@ design/pdsn_pkg.sv @@
// ----------------------------------------------------------------------------
// pdsn_pkg
// Types and codes shared by the sink negotiator: policy states, event codes,
// timer codes, register map, configuration and result records.
// ----------------------------------------------------------------------------
package pdsn_pkg;

    typedef enum logic [2:0]
    {
        ST_WAIT_ATTACH = 3'd0,
        ST_WAIT_CAPS   = 3'd1,
        ST_WAIT_ACCEPT = 3'd2,
        ST_WAIT_PS_RDY = 3'd3,
        ST_READY       = 3'd4,
        ST_SOFT_RESET  = 3'd5,
        ST_HARD_RESET  = 3'd6
    } state_t;

    typedef enum logic [3:0]
    {
        CMD_ATTACH       = 4'd0,
        CMD_DETACH       = 4'd1,
        CMD_CAPS_PDO     = 4'd2,
        CMD_ACCEPT       = 4'd3,
        CMD_REJECT       = 4'd4,
        CMD_PS_RDY       = 4'd5,
        CMD_SOFT_RESET   = 4'd6,
        CMD_HARD_RESET   = 4'd7,
        CMD_CAPS_TIMEOUT = 4'd8,
        CMD_RESP_TIMEOUT = 4'd9
    } cmd_t;

    localparam logic [1:0] TMR_NONE = 2'd0;
    localparam logic [1:0] TMR_CAPS = 2'd1;
    localparam logic [1:0] TMR_RESP = 2'd2;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_PREF_MV        = 3'd0;
    localparam logic [2:0] REG_PREF_MA        = 3'd1;
    localparam logic [2:0] REG_FB_MV          = 3'd2;
    localparam logic [2:0] REG_FB_MA          = 3'd3;
    localparam logic [2:0] REG_WAIT_CAPS_MS   = 3'd4;
    localparam logic [2:0] REG_ACCEPT_WAIT_MS = 3'd5;
    localparam logic [2:0] REG_READY_WAIT_MS  = 3'd6;

    localparam int ADDR_W = 5;

    typedef struct packed
    {
        logic [15:0] pref_mv;
        logic [13:0] pref_ma;
        logic [15:0] fb_mv;
        logic [13:0] fb_ma;
        logic [15:0] wait_caps_ms;
        logic [15:0] accept_wait_ms;
        logic [15:0] ready_wait_ms;
    } cfg_t;

    // first member sits in the highest bits, so state lands at bit 0
    typedef struct packed
    {
        logic [15:0] timer_ms;
        logic [1:0]  timer_arm;
        logic [1:0]  timer_cancel;
        logic        send_accept;
        logic        send_hard_reset;
        logic        send_soft_reset;
        logic [13:0] request_current_ma;
        logic [2:0]  request_position;
        logic        req_send;
        logic        state_changed;
        logic [2:0]  state;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ design/pdsn_cfg.sv @@
// ----------------------------------------------------------------------------
// pdsn_cfg
// APB register file holding the voltage, current and timer settings.
// ----------------------------------------------------------------------------
module pdsn_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdsn_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pdsn_pkg::cfg_t              cfg
);
    import pdsn_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pref_mv        <= 16'd5000;
            cfg_reg.pref_ma        <= 14'd500;
            cfg_reg.fb_mv          <= 16'd5000;
            cfg_reg.fb_ma          <= 14'd100;
            cfg_reg.wait_caps_ms   <= 16'd500;
            cfg_reg.accept_wait_ms <= 16'd30;
            cfg_reg.ready_wait_ms  <= 16'd500;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PREF_MV:        cfg_reg.pref_mv        <= pwdata[15:0];
                REG_PREF_MA:        cfg_reg.pref_ma        <= pwdata[13:0];
                REG_FB_MV:          cfg_reg.fb_mv          <= pwdata[15:0];
                REG_FB_MA:          cfg_reg.fb_ma          <= pwdata[13:0];
                REG_WAIT_CAPS_MS:   cfg_reg.wait_caps_ms   <= pwdata[15:0];
                REG_ACCEPT_WAIT_MS: cfg_reg.accept_wait_ms <= pwdata[15:0];
                REG_READY_WAIT_MS:  cfg_reg.ready_wait_ms  <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PREF_MV:        prdata = {16'd0, cfg_reg.pref_mv};
            REG_PREF_MA:        prdata = {18'd0, cfg_reg.pref_ma};
            REG_FB_MV:          prdata = {16'd0, cfg_reg.fb_mv};
            REG_FB_MA:          prdata = {18'd0, cfg_reg.fb_ma};
            REG_WAIT_CAPS_MS:   prdata = {16'd0, cfg_reg.wait_caps_ms};
            REG_ACCEPT_WAIT_MS: prdata = {16'd0, cfg_reg.accept_wait_ms};
            REG_READY_WAIT_MS:  prdata = {16'd0, cfg_reg.ready_wait_ms};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

@@ design/pdsn_policy.sv @@
// ----------------------------------------------------------------------------
// pdsn_policy
// Sink policy state machine with the running PDO selection; computes the
// result of one event and updates its state when the event is stepped.
// ----------------------------------------------------------------------------
module pdsn_policy
#(
    parameter int MAX_OBJECTS = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [3:0]        cmd,
    input  logic [31:0]       pdo,
    input  logic              pdo_present,
    input  logic              pdo_last,
    input  pdsn_pkg::cfg_t    cfg,
    output pdsn_pkg::result_t res
);
    import pdsn_pkg::*;

    localparam logic [2:0] MAX_IDX = 3'(MAX_OBJECTS);

    state_t      state_reg, state_next;
    logic [2:0]  pdo_index_reg;
    logic        best_found_reg;
    logic [15:0] best_delta_reg;
    logic [2:0]  best_pos_reg;
    logic        fb_found_reg;
    logic [2:0]  fb_pos_reg;

    cmd_t        cmd_e;
    logic        in_caps;
    logic        take;
    logic        msg_end;
    logic [15:0] mv;
    logic [13:0] ma;
    logic [15:0] delta;
    logic [2:0]  pos;
    logic        pref_ok;
    logic        upd_best;
    logic        upd_fb;
    logic        sel_best;
    logic        sel_fb;
    logic [2:0]  sel_best_pos;
    logic [2:0]  sel_fb_pos;
    logic        clear_sel;

    assign cmd_e   = cmd_t'(cmd);
    assign in_caps = (state_reg == ST_WAIT_CAPS) && (cmd_e == CMD_CAPS_PDO);
    assign take    = in_caps && pdo_present && (pdo_index_reg < MAX_IDX);
    assign msg_end = in_caps && (!pdo_present || pdo_last);

    assign mv    = 16'({6'd0, pdo[19:10]} * 16'd50);
    assign ma    = 14'({4'd0, pdo[9:0]} * 14'd10);
    assign delta = cfg.pref_mv - mv;
    assign pos   = pdo_index_reg + 3'd1;

    assign pref_ok  = (mv != 16'd0) && (ma != 14'd0) && (mv <= cfg.pref_mv)
                      && (ma >= cfg.pref_ma);
    assign upd_best = take && pref_ok && (!best_found_reg || (delta < best_delta_reg));
    assign upd_fb   = take && !fb_found_reg && (mv == cfg.fb_mv)
                      && (ma >= cfg.fb_ma);

    // selection including the current pdo
    assign sel_best     = best_found_reg | upd_best;
    assign sel_best_pos = upd_best ? pos : best_pos_reg;
    assign sel_fb       = fb_found_reg | upd_fb;
    assign sel_fb_pos   = upd_fb ? pos : fb_pos_reg;

    always_comb
    begin
        state_next = state_reg;
        res        = '0;
        case (state_reg)
            ST_WAIT_ATTACH:
            begin
                if (cmd_e == CMD_ATTACH)
                begin
                    state_next    = ST_WAIT_CAPS;
                    res.timer_arm = TMR_CAPS;
                    res.timer_ms  = cfg.wait_caps_ms;
                end
            end
            ST_WAIT_CAPS:
            begin
                if (msg_end)
                begin
                    res.timer_cancel = TMR_CAPS;
                    if (sel_best || sel_fb)
                    begin
                        state_next             = ST_WAIT_ACCEPT;
                        res.req_send           = 1'b1;
                        res.request_position   = sel_best ? sel_best_pos : sel_fb_pos;
                        res.request_current_ma = sel_best ? cfg.pref_ma
                                                          : cfg.fb_ma;
                        res.timer_arm          = TMR_RESP;
                        res.timer_ms           = cfg.accept_wait_ms;
                    end
                    else
                    begin
                        state_next          = ST_SOFT_RESET;
                        res.send_soft_reset = 1'b1;
                    end
                end
                else if (cmd_e == CMD_CAPS_TIMEOUT)
                begin
                    state_next          = ST_HARD_RESET;
                    res.send_hard_reset = 1'b1;
                end
            end
            ST_WAIT_ACCEPT:
            begin
                if (cmd_e == CMD_ACCEPT)
                begin
                    state_next       = ST_WAIT_PS_RDY;
                    res.timer_cancel = TMR_RESP;
                    res.timer_arm    = TMR_RESP;
                    res.timer_ms     = cfg.ready_wait_ms;
                end
                else if ((cmd_e == CMD_REJECT) || (cmd_e == CMD_RESP_TIMEOUT))
                begin
                    state_next    = ST_WAIT_CAPS;
                    res.timer_arm = TMR_CAPS;
                    res.timer_ms  = cfg.wait_caps_ms;
                end
            end
            ST_WAIT_PS_RDY:
            begin
                if (cmd_e == CMD_PS_RDY)
                begin
                    state_next       = ST_READY;
                    res.timer_cancel = TMR_RESP;
                end
                else if (cmd_e == CMD_RESP_TIMEOUT)
                begin
                    state_next          = ST_HARD_RESET;
                    res.send_hard_reset = 1'b1;
                end
            end
            ST_READY:
            begin
                if (cmd_e == CMD_DETACH)
                begin
                    state_next = ST_WAIT_ATTACH;
                end
                else if (cmd_e == CMD_SOFT_RESET)
                begin
                    state_next      = ST_WAIT_CAPS;
                    res.send_accept = 1'b1;
                    res.timer_arm   = TMR_CAPS;
                    res.timer_ms    = cfg.wait_caps_ms;
                end
                else if (cmd_e == CMD_HARD_RESET)
                begin
                    state_next          = ST_HARD_RESET;
                    res.send_hard_reset = 1'b1;
                end
            end
            ST_SOFT_RESET, ST_HARD_RESET:
            begin
                if (cmd_e == CMD_DETACH)
                begin
                    state_next = ST_WAIT_ATTACH;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
        res.state         = state_next;
        res.state_changed = (state_next != state_reg);
    end

    // cleared when a message ends and on every entry into wait caps
    assign clear_sel = msg_end
                       || ((state_next == ST_WAIT_CAPS) && (state_reg != ST_WAIT_CAPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_WAIT_ATTACH;
            pdo_index_reg  <= 3'd0;
            best_found_reg <= 1'b0;
            best_delta_reg <= 16'hFFFF;
            best_pos_reg   <= 3'd0;
            fb_found_reg   <= 1'b0;
            fb_pos_reg     <= 3'd0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            if (clear_sel)
            begin
                pdo_index_reg  <= 3'd0;
                best_found_reg <= 1'b0;
                best_delta_reg <= 16'hFFFF;
                best_pos_reg   <= 3'd0;
                fb_found_reg   <= 1'b0;
                fb_pos_reg     <= 3'd0;
            end
            else if (take)
            begin
                pdo_index_reg  <= pos;
                best_found_reg <= sel_best;
                best_pos_reg   <= sel_best_pos;
                fb_found_reg   <= sel_fb;
                fb_pos_reg     <= sel_fb_pos;
                if (upd_best)
                begin
                    best_delta_reg <= delta;
                end
            end
        end
    end

endmodule

@@ design/power_delivery_sink_negotiator.sv @@
// ----------------------------------------------------------------------------
// power_delivery_sink_negotiator
// Sink-side contract negotiation: one policy event in, one result out.
// ----------------------------------------------------------------------------
// Events enter on the s_axis channel: command and the pdo_present flag in
// tuser, the raw fixed PDO word in tdata, tlast on the final PDO of a
// source capabilities message. Each event gives exactly one result item on
// m_axis: the new state, a state change flag and the actions to take
// (request with position and current, soft or hard reset, accept, timer
// cancel and arm with length). Settings are to be written over the APB port
// only while no event is in flight; the block does not enforce this.
// An accepted item is held in an input register; the policy logic and the
// PDO selection compare run combinationally between that register and the
// output register, which loads the result when the input register advances,
// and a new item is taken every cycle while the receiver does not stall.
// When the receiver stalls, the output register holds its item and the
// input register takes one more item before tready drops. Reset clears both
// stages, puts the policy in wait for attach with an empty selection and
// loads the default settings.
// ----------------------------------------------------------------------------
module power_delivery_sink_negotiator
#(
    parameter int MAX_OBJECTS = 7
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,   // pdo
    input  logic [4:0]                      s_axis_tuser,   // command[3:0], pdo_present
    input  logic                            s_axis_tlast,   // pdo_last
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // state[2:0], state_changed, req_send, request_position[2:0],
    // request_current_ma[13:0], send_soft_reset, send_hard_reset,
    // send_accept, timer_cancel[1:0], timer_arm[1:0], timer_ms[15:0], zero fill
    output logic [pdsn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdsn_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import pdsn_pkg::*;

    cfg_t        cfg;
    result_t     step_res;
    logic        advance;

    logic        in_valid_reg;
    logic [3:0]  in_cmd_reg;
    logic [31:0] in_pdo_reg;
    logic        in_present_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    result_t     out_res_reg;

    // input stage moves on when the output register is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    pdsn_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdsn_policy #(.MAX_OBJECTS(MAX_OBJECTS)) u_policy
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .cmd         (in_cmd_reg),
        .pdo         (in_pdo_reg),
        .pdo_present (in_present_reg),
        .pdo_last    (in_last_reg),
        .cfg         (cfg),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg     <= s_axis_tuser[3:0];
            in_present_reg <= s_axis_tuser[4];
            in_pdo_reg     <= s_axis_tdata;
            in_last_reg    <= s_axis_tlast;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_res_reg};

endmodule

@@ test/power_delivery_sink_negotiator_tb.sv @@
// ----------------------------------------------------------------------------
// power_delivery_sink_negotiator_tb
// Self-checking bench for the sink-side PD contract negotiator. A short table
// of events walks the policy through attach, capability messages, selection
// corner cases and resets; then random event streams, mostly well-formed
// negotiations with some noise, run under several register settings. Every
// result item is checked field by field against its table row or a model of
// the policy and selection in the bench, with random stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module power_delivery_sink_negotiator_tb;

    import pdsn_pkg::*;

    localparam int         OFFER_SLOTS   = 7;
    localparam int         WATCHDOG_MAX  = 3000;
    localparam logic [3:0] CMD_UNDEFINED = 4'd15;
    localparam logic [2:0] REG_UNUSED    = 3'd7;

    typedef struct
    {
        logic [3:0]  cmd;
        logic [31:0] pdo;
        logic        present;
        logic        last;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;   // pdo
    logic [4:0]            s_axis_tuser;   // command[3:0], pdo_present
    logic                  s_axis_tlast;   // pdo_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // state[2:0], state_changed, req_send, request_position[2:0],
    // request_current_ma[13:0], send_soft_reset, send_hard_reset,
    // send_accept, timer_cancel[1:0], timer_arm[1:0], timer_ms[15:0], zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // policy model
    cfg_t        cfg_model;
    state_t      pol_state;
    int          offers_seen;
    bit          best_hit;
    logic [15:0] best_gap;
    logic [2:0]  best_pos;
    bit          fb_hit;
    logic [2:0]  fb_pos;

    result_t     expected_results[$];
    stim_row_t   plan[$];
    bit          row_typed;
    result_t     row_exp;
    bit          no_idle;
    int          sink_hold;
    int          progress_events;
    int          idle_cycles;
    int          fail_count;

    power_delivery_sink_negotiator
    #(
        .MAX_OBJECTS(OFFER_SLOTS)
    )
    u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] pdo_word(int unsigned volt_steps, int unsigned amp_steps);
        return {12'd0, volt_steps[9:0], amp_steps[9:0]};
    endfunction

    function automatic result_t outcome(state_t st, bit chg, bit soft_rst, bit hard,
                                        logic [1:0] cancel, logic [1:0] arm,
                                        logic [15:0] ms);
        result_t r;
        r = '0;
        r.state           = st;
        r.state_changed   = chg;
        r.send_soft_reset = soft_rst;
        r.send_hard_reset = hard;
        r.timer_cancel    = cancel;
        r.timer_arm       = arm;
        r.timer_ms        = ms;
        return r;
    endfunction

    function automatic void clear_offers();
        offers_seen = 0;
        best_hit    = 1'b0;
        best_gap    = 16'hFFFF;
        best_pos    = '0;
        fb_hit      = 1'b0;
        fb_pos      = '0;
    endfunction

    function automatic void add_offer(logic [31:0] word);
        int unsigned mv;
        int unsigned ma;
        logic [15:0] gap_mv;
        logic [2:0]  pos;
        if (offers_seen >= OFFER_SLOTS)
            return;
        mv  = int'(word[19:10]) * 50;
        ma  = int'(word[9:0]) * 10;
        pos = 3'(offers_seen + 1);
        if (mv != 0 && ma != 0 && mv <= cfg_model.pref_mv && ma >= cfg_model.pref_ma)
        begin
            gap_mv = cfg_model.pref_mv - mv[15:0];
            // strict compare keeps the earliest offer on a tie
            if (!best_hit || gap_mv < best_gap)
            begin
                best_gap = gap_mv;
                best_pos = pos;
                best_hit = 1'b1;
            end
        end
        if (!fb_hit && mv == cfg_model.fb_mv && ma >= cfg_model.fb_ma)
        begin
            fb_hit = 1'b1;
            fb_pos = pos;
        end
        offers_seen++;
    endfunction

    function automatic result_t negotiate(logic [3:0] cmd, logic [31:0] word,
                                          logic present, logic last);
        result_t r;
        state_t  nxt;
        r   = '0;
        nxt = pol_state;
        case (pol_state)
            ST_WAIT_ATTACH:
            begin
                if (cmd == CMD_ATTACH)
                begin
                    nxt         = ST_WAIT_CAPS;
                    r.timer_arm = TMR_CAPS;
                    r.timer_ms  = cfg_model.wait_caps_ms;
                end
            end
            ST_WAIT_CAPS:
            begin
                if (cmd == CMD_CAPS_PDO)
                begin
                    if (present)
                        add_offer(word);
                    // an empty message ends the message whatever tlast says
                    if (!present || last)
                    begin
                        r.timer_cancel = TMR_CAPS;
                        if (best_hit || fb_hit)
                        begin
                            r.req_send           = 1'b1;
                            r.request_position   = best_hit ? best_pos : fb_pos;
                            r.request_current_ma = best_hit ? cfg_model.pref_ma
                                                            : cfg_model.fb_ma;
                            r.timer_arm          = TMR_RESP;
                            r.timer_ms           = cfg_model.accept_wait_ms;
                            nxt                  = ST_WAIT_ACCEPT;
                        end
                        else
                        begin
                            r.send_soft_reset = 1'b1;
                            nxt               = ST_SOFT_RESET;
                        end
                        clear_offers();
                    end
                end
                else if (cmd == CMD_CAPS_TIMEOUT)
                begin
                    r.send_hard_reset = 1'b1;
                    nxt               = ST_HARD_RESET;
                end
            end
            ST_WAIT_ACCEPT:
            begin
                if (cmd == CMD_ACCEPT)
                begin
                    r.timer_cancel = TMR_RESP;
                    r.timer_arm    = TMR_RESP;
                    r.timer_ms     = cfg_model.ready_wait_ms;
                    nxt            = ST_WAIT_PS_RDY;
                end
                else if (cmd == CMD_REJECT || cmd == CMD_RESP_TIMEOUT)
                begin
                    nxt         = ST_WAIT_CAPS;
                    r.timer_arm = TMR_CAPS;
                    r.timer_ms  = cfg_model.wait_caps_ms;
                end
            end
            ST_WAIT_PS_RDY:
            begin
                if (cmd == CMD_PS_RDY)
                begin
                    r.timer_cancel = TMR_RESP;
                    nxt            = ST_READY;
                end
                else if (cmd == CMD_RESP_TIMEOUT)
                begin
                    r.send_hard_reset = 1'b1;
                    nxt               = ST_HARD_RESET;
                end
            end
            ST_READY:
            begin
                if (cmd == CMD_DETACH)
                    nxt = ST_WAIT_ATTACH;
                else if (cmd == CMD_SOFT_RESET)
                begin
                    r.send_accept = 1'b1;
                    nxt           = ST_WAIT_CAPS;
                    r.timer_arm   = TMR_CAPS;
                    r.timer_ms    = cfg_model.wait_caps_ms;
                end
                else if (cmd == CMD_HARD_RESET)
                begin
                    r.send_hard_reset = 1'b1;
                    nxt               = ST_HARD_RESET;
                end
            end
            ST_SOFT_RESET, ST_HARD_RESET:
            begin
                if (cmd == CMD_DETACH)
                    nxt = ST_WAIT_ATTACH;
            end
            default:
            begin
            end
        endcase
        if (nxt == ST_WAIT_CAPS && pol_state != ST_WAIT_CAPS)
            clear_offers();
        r.state         = nxt;
        r.state_changed = (nxt != pol_state);
        pol_state       = nxt;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    task automatic add_row(logic [3:0] cmd, logic [31:0] pdo, logic present, logic last,
                           bit typed, result_t want);
        stim_row_t row;
        row.cmd     = cmd;
        row.pdo     = pdo;
        row.present = present;
        row.last    = last;
        row.typed   = typed;
        row.want    = want;
        plan.push_back(row);
    endtask

    // called just after a falling edge; returns at the edge that takes the item
    task automatic send_item(logic [3:0] cmd, logic [31:0] pdo, logic present, logic last,
                             bit typed, result_t want);
        int gap;
        gap = no_idle ? 0 : pause_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= pdo;
        s_axis_tuser  <= {present, cmd};
        s_axis_tlast  <= last;
        row_typed     <= typed;
        row_exp       <= want;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_reg(logic [2:0] idx, logic [15:0] value);
        logic [31:0] mask;
        logic [31:0] data;
        mask = (idx == REG_PREF_MA || idx == REG_FB_MA) ? 32'h3FFF : 32'hFFFF;
        // junk above the register width must be dropped
        data = ($urandom() & ~mask) | ({16'd0, value} & mask);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_PREF_MV:        cfg_model.pref_mv        = data[15:0];
            REG_PREF_MA:        cfg_model.pref_ma        = data[13:0];
            REG_FB_MV:          cfg_model.fb_mv          = data[15:0];
            REG_FB_MA:          cfg_model.fb_ma          = data[13:0];
            REG_WAIT_CAPS_MS:   cfg_model.wait_caps_ms   = data[15:0];
            REG_ACCEPT_WAIT_MS: cfg_model.accept_wait_ms = data[15:0];
            REG_READY_WAIT_MS:  cfg_model.ready_wait_ms  = data[15:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        if (idx == REG_UNUSED)
        begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        else
        begin
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== (data & mask))
            begin
                fail_count++;
                $error("register %0d readback: expected %0h, got %0h", idx, data & mask, prdata);
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic apply_setting(int which);
        logic [15:0] pmv, pma, fmv, fma, caps_ms, acc_ms, rdy_ms;
        case (which)
            0:
            begin
                pmv = 16'd51150; pma = 16'd10230; fmv = 16'd51150; fma = 16'd10230;
                caps_ms = 16'hFFFF; acc_ms = 16'hFFFF; rdy_ms = 16'hFFFF;
            end
            1:
            begin
                pmv = '0; pma = '0; fmv = '0; fma = '0;
                caps_ms = '0; acc_ms = '0; rdy_ms = '0;
            end
            default:
            begin
                pmv     = 16'(50 * $urandom_range(60, 400));
                pma     = 16'(10 * $urandom_range(0, 500));
                fmv     = 16'(50 * $urandom_range(60, 400));
                fma     = 16'(10 * $urandom_range(0, 300));
                caps_ms = 16'($urandom_range(0, 65535));
                acc_ms  = 16'($urandom_range(0, 65535));
                rdy_ms  = 16'($urandom_range(0, 65535));
            end
        endcase
        program_reg(REG_PREF_MV, pmv);
        program_reg(REG_PREF_MA, pma);
        program_reg(REG_FB_MV, fmv);
        program_reg(REG_FB_MA, fma);
        program_reg(REG_WAIT_CAPS_MS, caps_ms);
        program_reg(REG_ACCEPT_WAIT_MS, acc_ms);
        program_reg(REG_READY_WAIT_MS, rdy_ms);
        program_reg(REG_UNUSED, 16'($urandom()));
    endtask

    task automatic run_phase(int goal);
        int          target;
        int          msg_len;
        int          msg_seen;
        int          pick;
        int          r;
        int unsigned v;
        int unsigned c;
        int unsigned sub;
        logic [3:0]  cmd;
        logic [31:0] word;
        logic        present;
        logic        last;
        target   = progress_events + goal;
        msg_len  = 1;
        msg_seen = 0;
        while (progress_events < target)
        begin
            @(negedge clk);
            word    = $urandom();
            present = $urandom_range(0, 1);
            last    = $urandom_range(0, 1);
            pick    = $urandom_range(0, 99);
            r       = $urandom_range(0, 9);
            if (pol_state != ST_WAIT_CAPS)
                msg_seen = 0;
            if (pick < 15)
            begin
                // noise: any code, including the undefined ones
                cmd      = 4'($urandom_range(0, 15));
                msg_seen = 0;
            end
            else
            begin
                case (pol_state)
                    ST_WAIT_ATTACH:
                        cmd = CMD_ATTACH;
                    ST_WAIT_CAPS:
                    begin
                        if (pick < 19)
                            cmd = CMD_CAPS_TIMEOUT;
                        else
                        begin
                            if (msg_seen == 0)
                            begin
                                sub = $urandom_range(0, 99);
                                if (sub < 85)
                                    msg_len = $urandom_range(1, 4);
                                else if (sub < 95)
                                    msg_len = $urandom_range(5, 7);
                                else
                                    msg_len = $urandom_range(8, 9);
                            end
                            // voltages and currents mostly around the configured targets
                            if (r < 4)
                            begin
                                v   = cfg_model.pref_mv / 50;
                                sub = $urandom_range(0, 4);
                                v   = (v > sub) ? v - sub : 0;
                            end
                            else if (r < 6)
                                v = cfg_model.fb_mv / 50;
                            else
                                v = $urandom_range(0, 1023);
                            if (v > 1023)
                                v = 1023;
                            r = $urandom_range(0, 9);
                            if (r < 5)
                                c = cfg_model.pref_ma / 10 + $urandom_range(0, 3);
                            else if (r < 7)
                                c = cfg_model.fb_ma / 10 + $urandom_range(0, 3);
                            else
                                c = $urandom_range(1, 1024);
                            c = (c > 0) ? c - 1 : 0;
                            if (c > 1023)
                                c = 1023;
                            cmd     = CMD_CAPS_PDO;
                            word    = {word[31:20], v[9:0], c[9:0]};
                            present = ($urandom_range(0, 19) != 0);
                            msg_seen++;
                            last    = (msg_seen >= msg_len);
                            if (!present || last)
                                msg_seen = 0;
                        end
                    end
                    ST_WAIT_ACCEPT:
                        cmd = (r < 6) ? CMD_ACCEPT : (r < 8) ? CMD_REJECT : CMD_RESP_TIMEOUT;
                    ST_WAIT_PS_RDY:
                        cmd = (r < 7) ? CMD_PS_RDY : CMD_RESP_TIMEOUT;
                    ST_READY:
                        cmd = (r < 4) ? CMD_DETACH : (r < 7) ? CMD_SOFT_RESET : CMD_HARD_RESET;
                    default:
                        cmd = CMD_DETACH;
                endcase
            end
            send_item(cmd, word, present, last, 1'b0, '0);
        end
    endtask

    // input items are predicted on acceptance, result items checked in order
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        state_t  prior;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                prior = pol_state;
                want  = negotiate(s_axis_tuser[3:0], s_axis_tdata, s_axis_tuser[4], s_axis_tlast);
                if (want.state_changed || (prior == ST_WAIT_CAPS && s_axis_tuser[3:0] == CMD_CAPS_PDO))
                    progress_events++;
                expected_results.push_back(row_typed ? row_exp : want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[RESULT_W-1:0]);
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    $error("result item with none expected: %0h", m_axis_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("state", want.state, got.state);
                    check_field("state_changed", want.state_changed, got.state_changed);
                    check_field("req_send", want.req_send, got.req_send);
                    check_field("request_position", want.request_position, got.request_position);
                    check_field("request_current_ma", want.request_current_ma,
                                got.request_current_ma);
                    check_field("send_soft_reset", want.send_soft_reset, got.send_soft_reset);
                    check_field("send_hard_reset", want.send_hard_reset, got.send_hard_reset);
                    check_field("send_accept", want.send_accept, got.send_accept);
                    check_field("timer_cancel", want.timer_cancel, got.timer_cancel);
                    check_field("timer_arm", want.timer_arm, got.timer_arm);
                    check_field("timer_ms", want.timer_ms, got.timer_ms);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stalls: runs of ready and of back-pressure
    always @(negedge clk)
    begin
        if (sink_hold > 0)
            sink_hold--;
        else if (no_idle)
            m_axis_tready <= 1'b1;
        else if ($urandom_range(0, 2) == 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold = pause_len();
        end
        else
        begin
            m_axis_tready <= 1'b1;
            sink_hold = $urandom_range(0, 12);
        end
    end

    initial
    begin
        result_t no_act;
        result_t to_caps;
        result_t to_attach;
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        row_typed     = 1'b0;
        row_exp       = '0;
        no_idle       = 1'b0;
        sink_hold     = 0;
        progress_events = 0;
        idle_cycles   = 0;
        fail_count    = 0;

        cfg_model.pref_mv        = 16'd5000;
        cfg_model.pref_ma        = 14'd500;
        cfg_model.fb_mv          = 16'd5000;
        cfg_model.fb_ma          = 14'd100;
        cfg_model.wait_caps_ms   = 16'd500;
        cfg_model.accept_wait_ms = 16'd30;
        cfg_model.ready_wait_ms  = 16'd500;
        pol_state = ST_WAIT_ATTACH;
        clear_offers();

        no_act    = outcome(ST_WAIT_ATTACH, 1'b0, 1'b0, 1'b0, TMR_NONE, TMR_NONE, 16'd0);
        to_caps   = outcome(ST_WAIT_CAPS, 1'b1, 1'b0, 1'b0, TMR_NONE, TMR_CAPS, 16'd500);
        to_attach = outcome(ST_WAIT_ATTACH, 1'b1, 1'b0, 1'b0, TMR_NONE, TMR_NONE, 16'd0);

        // events out of place and undefined codes do nothing
        add_row(CMD_UNDEFINED, 32'h0, 1'b1, 1'b1, 1'b1, no_act);
        add_row(CMD_CAPS_PDO, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, no_act);
        add_row(CMD_ATTACH, 32'h0, 1'b0, 1'b0, 1'b1, to_caps);
        // eight offers, none usable in the first seven; the eighth is dropped
        add_row(CMD_CAPS_PDO, 32'h0, 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, pdo_word(1023, 0), 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, pdo_word(400, 300), 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, pdo_word(90, 10), 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, pdo_word(0, 1023), 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, pdo_word(100, 5), 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, pdo_word(100, 300), 1'b1, 1'b1, 1'b0, '0);
        add_row(CMD_DETACH, 32'h0, 1'b0, 1'b0, 1'b1, to_attach);
        add_row(CMD_ATTACH, 32'h0, 1'b0, 1'b0, 1'b1, to_caps);
        // closest voltage wins, an equal later offer does not displace it
        add_row(CMD_CAPS_PDO, pdo_word(90, 300), 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, pdo_word(100, 20), 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, 32'hFFF0_0000 | pdo_word(100, 300), 1'b1, 1'b0, 1'b0, '0);
        add_row(CMD_CAPS_PDO, pdo_word(100, 300), 1'b1, 1'b1, 1'b0, '0);
        add_row(CMD_ACCEPT, 32'h0, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_PS_RDY, 32'h0, 1'b0, 1'b0, 1'b0, '0);
        add_row(CMD_SOFT_RESET, 32'h0, 1'b0, 1'b0, 1'b0, '0);
        // only the fallback matches
        add_row(CMD_CAPS_PDO, pdo_word(100, 20), 1'b1, 1'b1, 1'b0, '0);
        add_row(CMD_REJECT, 32'h0, 1'b0, 1'b0, 1'b0, '0);
        // empty message, tlast low
        add_row(CMD_CAPS_PDO, 32'h0, 1'b0, 1'b0, 1'b1,
                outcome(ST_SOFT_RESET, 1'b1, 1'b1, 1'b0, TMR_CAPS, TMR_NONE, 16'd0));
        add_row(CMD_DETACH, 32'h0, 1'b0, 1'b0, 1'b1, to_attach);
        add_row(CMD_ATTACH, 32'h0, 1'b0, 1'b0, 1'b1, to_caps);
        add_row(CMD_CAPS_TIMEOUT, 32'h0, 1'b0, 1'b0, 1'b1,
                outcome(ST_HARD_RESET, 1'b1, 1'b0, 1'b1, TMR_NONE, TMR_NONE, 16'd0));
        add_row(CMD_DETACH, 32'h0, 1'b0, 1'b0, 1'b1, to_attach);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            @(negedge clk);
            send_item(plan[i].cmd, plan[i].pdo, plan[i].present, plan[i].last,
                      plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            apply_setting(p);
            no_idle = (p == 3);
            run_phase(180);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/pdsn_pkg.sv
design/pdsn_cfg.sv
design/pdsn_policy.sv
design/power_delivery_sink_negotiator.sv
test/power_delivery_sink_negotiator_tb.sv
